[rtl/core/rpn_pkg.sv]
// ---------------------------------------------------------------------------
// rpn_pkg
// shared types, constants and command codes of the rpn stack evaluator
// ---------------------------------------------------------------------------
package rpn_pkg;

   localparam int STACK_DEPTH   = 128;
   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int PTR_WIDTH     = $clog2(STACK_DEPTH);
   localparam int CNT_WIDTH     = $clog2(STACK_DEPTH + 1);
   localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
   localparam int DIV_STEPS     = VALUE_WIDTH + FRACTION_BITS;
   localparam int STEP_WIDTH    = $clog2(DIV_STEPS + 1);

   localparam logic [2:0] FUNC_PUSH = 3'd0;
   localparam logic [2:0] FUNC_ADD  = 3'd1;
   localparam logic [2:0] FUNC_SUB  = 3'd2;
   localparam logic [2:0] FUNC_MUL  = 3'd3;
   localparam logic [2:0] FUNC_DIV  = 3'd4;
   localparam logic [2:0] FUNC_REM  = 3'd5;
   localparam logic [2:0] FUNC_SHOW = 3'd6;
   localparam logic [2:0] FUNC_UNK  = 3'd7;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic       clear;        // new request: clear flags, latch func/operand
      logic       pop_start;    // read top entry
      logic       pop_take;     // capture read data into operand b or a
      logic       take_b;       // 1: into b, 0: into a
      logic       push;         // push result or operand
      logic       push_operand; // push the request operand rather than result
      logic       div_start;
      logic       mul_start;
      logic       alu_step;     // compute add/sub/rem result
      logic       zero_flag;
      logic       show;         // latch b as shown value
   } rpn_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       b_zero;
      logic       div_done;
      logic       mul_done;
   } rpn_stat_type;

endpackage

[rtl/core/rpn_if.sv]
// ---------------------------------------------------------------------------
// rpn_req_if / rpn_rsp_if
// valid/ready channels of the rpn stack evaluator
// ---------------------------------------------------------------------------
interface rpn_req_if import rpn_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] func;
   value_type  operand_value;
   modport source (output valid, func, operand_value, input ready);
   modport sink (input valid, func, operand_value, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type shown_value;
   logic      shown_valid;
   logic      underflow;
   logic      stack_full;
   logic      zero_divisor;
   logic      unknown_command;
   logic      saturated;
   modport source (output valid, shown_value, shown_valid, underflow, stack_full,
                   zero_divisor, unknown_command, saturated, input ready);
   modport sink (input valid, shown_value, shown_valid, underflow, stack_full,
                 zero_divisor, unknown_command, saturated, output ready);
endinterface

[rtl/core/rpn_ram.sv]
// ---------------------------------------------------------------------------
// rpn_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[rtl/core/rpn_datapath.sv]
// ---------------------------------------------------------------------------
// rpn_datapath
// stack, operand registers, saturating alu, multiplier and serial divider
// ---------------------------------------------------------------------------
module rpn_datapath import rpn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rpn_cmd_type  cmd,
   input  logic [2:0]   func,
   input  value_type    operand_value,
   output rpn_stat_type stat,
   output value_type    shown_value,
   output logic         underflow,
   output logic         stack_full,
   output logic         zero_divisor,
   output logic         saturated
);
   localparam logic [VALUE_WIDTH:0] POS_LIM = {2'b00, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH:0] NEG_LIM = {2'b01, {(VALUE_WIDTH-1){1'b0}}};
   localparam int NUM_WIDTH = VALUE_WIDTH + FRACTION_BITS;

   logic [CNT_WIDTH-1:0] count_ff, count_in;
   value_type a_ff, b_ff, res_ff, shown_ff;
   logic under_ff, full_ff, zero_ff, sat_ff;
   logic sel_b_ff;
   logic empty_pop_ff;
   logic [2:0] func_ff;
   value_type opnd_ff;
   logic [PTR_WIDTH-1:0] ram_addr;
   value_type ram_rd;
   logic ram_we;
   value_type push_val;

   // multiplier: magnitudes, one registered product
   logic [PROD_WIDTH-1:0] prod_ff;
   logic mul_busy_ff, mul_done_ff;
   logic mul_neg_ff;

   // divider
   logic [NUM_WIDTH-1:0]   num_ff;
   logic [VALUE_WIDTH:0]   rem_ff;
   logic [NUM_WIDTH-1:0]   quo_ff;
   logic [VALUE_WIDTH-1:0] den_ff;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic div_busy_ff, div_neg_ff;
   logic [VALUE_WIDTH:0]   rem_sh, rem_sub;

   logic [VALUE_WIDTH-1:0] mag_a, mag_b;
   logic [VALUE_WIDTH:0]   sum;

   assign mag_a = a_ff[VALUE_WIDTH-1] ? -a_ff : a_ff;
   assign mag_b = b_ff[VALUE_WIDTH-1] ? -b_ff : b_ff;

   assign stat.empty    = (count_ff == '0);
   assign stat.b_zero   = (b_ff == '0);
   assign stat.div_done = div_busy_ff && (step_ff == STEP_WIDTH'(DIV_STEPS));
   assign stat.mul_done = mul_done_ff;

   assign push_val = cmd.push_operand ? opnd_ff : res_ff;
   assign ram_we   = cmd.push && (count_ff != CNT_WIDTH'(STACK_DEPTH));
   assign ram_addr = cmd.push ? count_ff[PTR_WIDTH-1:0]
                              : PTR_WIDTH'(count_ff - CNT_WIDTH'(1));

   rpn_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (push_val),
      .rd_data (ram_rd)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.pop_start && count_ff != '0) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end else if (ram_we) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end
   end

   // sign-extended sum or difference, overflow shows in the top two bits
   always_comb begin
      if (func_ff == FUNC_SUB) begin
         sum = {a_ff[VALUE_WIDTH-1], a_ff} - {b_ff[VALUE_WIDTH-1], b_ff};
      end else begin
         sum = {a_ff[VALUE_WIDTH-1], a_ff} + {b_ff[VALUE_WIDTH-1], b_ff};
      end
   end

   assign rem_sh  = {rem_ff[VALUE_WIDTH-1:0], num_ff[NUM_WIDTH-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   // saturation of a NUM_WIDTH-bit magnitude to a signed value
   function automatic value_type sat_mag(input logic [NUM_WIDTH-1:0] m,
                                         input logic neg, output logic s);
      logic [NUM_WIDTH-1:0] lim;
      begin
         lim = neg ? NUM_WIDTH'(NEG_LIM) : NUM_WIDTH'(POS_LIM);
         s = (m > lim);
         if (s) m = lim;
         sat_mag = neg ? value_type'(-m[VALUE_WIDTH-1:0])
                       : value_type'(m[VALUE_WIDTH-1:0]);
      end
   endfunction

   always_ff @(posedge clock) begin
      logic s;
      logic [PROD_WIDTH-1:0] pm;
      if (reset) begin
         count_ff    <= '0;
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
         div_busy_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         mul_busy_ff <= cmd.mul_start;
         mul_done_ff <= mul_busy_ff;
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
         end else if (stat.div_done) begin
            div_busy_ff <= 1'b0;
         end
      end
      if (cmd.clear) begin
         under_ff <= 1'b0;
         full_ff  <= 1'b0;
         zero_ff  <= 1'b0;
         sat_ff   <= 1'b0;
         shown_ff <= '0;
         b_ff     <= '0;
         a_ff     <= '0;
         func_ff  <= func;
         opnd_ff  <= operand_value;
      end
      if (cmd.pop_start) begin
         sel_b_ff     <= cmd.take_b;
         empty_pop_ff <= (count_ff == '0);
         if (count_ff == '0) under_ff <= 1'b1;
      end
      // a pop from an empty stack yields zero
      if (cmd.pop_take) begin
         if (sel_b_ff) b_ff <= empty_pop_ff ? '0 : ram_rd;
         else          a_ff <= empty_pop_ff ? '0 : ram_rd;
      end
      if (cmd.push && count_ff == CNT_WIDTH'(STACK_DEPTH)) full_ff <= 1'b1;
      if (cmd.zero_flag) zero_ff <= 1'b1;
      if (cmd.show) shown_ff <= b_ff;
      if (cmd.alu_step) begin
         if (func_ff == FUNC_REM) begin
            res_ff <= a_ff[VALUE_WIDTH-1] ? -value_type'(rem_ff[VALUE_WIDTH-1:0])
                                          : value_type'(rem_ff[VALUE_WIDTH-1:0]);
         end else begin
            if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) begin
               sat_ff <= 1'b1;
               res_ff <= sum[VALUE_WIDTH] ? value_type'(NEG_LIM[VALUE_WIDTH-1:0])
                                          : value_type'(POS_LIM[VALUE_WIDTH-1:0]);
            end else begin
               res_ff <= sum[VALUE_WIDTH-1:0];
            end
         end
      end
      if (cmd.mul_start) begin
         prod_ff    <= PROD_WIDTH'(mag_a) * PROD_WIDTH'(mag_b);
         mul_neg_ff <= a_ff[VALUE_WIDTH-1] ^ b_ff[VALUE_WIDTH-1];
      end
      if (mul_busy_ff) begin
         pm = prod_ff >> FRACTION_BITS;
         if (pm[PROD_WIDTH-1:NUM_WIDTH] != '0) begin
            sat_ff <= 1'b1;
            res_ff <= mul_neg_ff ? value_type'(NEG_LIM[VALUE_WIDTH-1:0])
                                 : value_type'(POS_LIM[VALUE_WIDTH-1:0]);
         end else begin
            res_ff <= sat_mag(pm[NUM_WIDTH-1:0], mul_neg_ff, s);
            if (s) sat_ff <= 1'b1;
         end
      end
      // remainder divides the plain magnitude, divide the scaled one
      if (cmd.div_start) begin
         num_ff     <= (func_ff == FUNC_REM) ? NUM_WIDTH'(mag_a)
                                             : {mag_a, {FRACTION_BITS{1'b0}}};
         den_ff     <= mag_b;
         rem_ff     <= '0;
         quo_ff     <= '0;
         step_ff    <= '0;
         div_neg_ff <= a_ff[VALUE_WIDTH-1] ^ b_ff[VALUE_WIDTH-1];
      end else if (div_busy_ff && !stat.div_done) begin
         num_ff  <= num_ff << 1;
         step_ff <= step_ff + STEP_WIDTH'(1);
         if (!rem_sub[VALUE_WIDTH]) begin
            rem_ff <= rem_sub;
            quo_ff <= {quo_ff[NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[NUM_WIDTH-2:0], 1'b0};
         end
      end
      if (stat.div_done && func_ff == FUNC_DIV) begin
         res_ff <= sat_mag(quo_ff, div_neg_ff, s);
         if (s) sat_ff <= 1'b1;
      end
   end

   assign shown_value  = shown_ff;
   assign underflow    = under_ff;
   assign stack_full   = full_ff;
   assign zero_divisor = zero_ff;
   assign saturated    = sat_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(STACK_DEPTH))
      else $error("stack count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> div_busy_ff)
      else $error("divider failed to start");
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop_start && cmd.push))
      else $error("pop and push in one cycle");
endmodule

[rtl/core/rpn_ctrl.sv]
// ---------------------------------------------------------------------------
// rpn_ctrl
// sequencer of pops, operations and pushes for one request
// ---------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [2:0]   req_func,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  rpn_stat_type stat,
   output rpn_cmd_type  cmd,
   output logic         shown_valid,
   output logic         unknown_command
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_POPB  = 4'd1;
   localparam logic [3:0] ST_TAKEB = 4'd2;
   localparam logic [3:0] ST_POPA  = 4'd3;
   localparam logic [3:0] ST_TAKEA = 4'd4;
   localparam logic [3:0] ST_OP    = 4'd5;
   localparam logic [3:0] ST_WAIT  = 4'd6;
   localparam logic [3:0] ST_PUSH  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;
   localparam logic [3:0] ST_CHECK = 4'd9;
   localparam logic [3:0] ST_REM   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [2:0] func_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign shown_valid = (func_ff == FUNC_SHOW);
   assign unknown_command = (func_ff == FUNC_UNK);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.clear = 1'b1;
               case (req_func)
                  FUNC_PUSH: state_in = ST_PUSH;
                  FUNC_UNK:  state_in = ST_DONE;
                  default:   state_in = ST_POPB;
               endcase
            end
         end
         ST_POPB: begin
            cmd.pop_start = 1'b1;
            cmd.take_b    = 1'b1;
            state_in      = ST_TAKEB;
         end
         ST_TAKEB: begin
            cmd.pop_take = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (func_ff == FUNC_SHOW) begin
               cmd.show = 1'b1;
               state_in = ST_DONE;
            end else if ((func_ff inside {FUNC_DIV, FUNC_REM}) && stat.b_zero) begin
               cmd.zero_flag = 1'b1;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_POPA;
            end
         end
         ST_POPA: begin
            cmd.pop_start = 1'b1;
            state_in      = ST_TAKEA;
         end
         ST_TAKEA: begin
            cmd.pop_take = 1'b1;
            state_in     = ST_OP;
         end
         ST_OP: begin
            case (func_ff)
               FUNC_MUL: begin
                  cmd.mul_start = 1'b1;
                  state_in = ST_WAIT;
               end
               FUNC_DIV, FUNC_REM: begin
                  cmd.div_start = 1'b1;
                  state_in = ST_WAIT;
               end
               default: begin
                  cmd.alu_step = 1'b1;
                  state_in = ST_PUSH;
               end
            endcase
         end
         ST_WAIT: begin
            if (stat.mul_done) begin
               state_in = ST_PUSH;
            end else if (stat.div_done) begin
               state_in = (func_ff == FUNC_REM) ? ST_REM : ST_PUSH;
            end
         end
         // remainder is signed by the alu once the divider is done
         ST_REM: begin
            cmd.alu_step = 1'b1;
            state_in     = ST_PUSH;
         end
         ST_PUSH: begin
            cmd.push         = 1'b1;
            cmd.push_operand = (func_ff == FUNC_PUSH);
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.clear) func_ff <= req_func;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid)
      else $error("done without response");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");
endmodule

[rtl/core/rpn_stack_evaluator.sv]
// ---------------------------------------------------------------------------
// rpn_stack_evaluator
// reverse polish evaluator over signed q16.16 values
// ---------------------------------------------------------------------------
// One request at a time; each request yields exactly one response. Divide
// and remainder run through the one-bit-per-cycle restoring divider (48
// steps). The stack lives in a single-port ram with a registered read, so
// each pop takes a read state and then a take state. Flags describe only
// the request they come with. A new request is taken in the cycle after
// the previous response has been taken.
module rpn_stack_evaluator import rpn_pkg::*; (
   input logic         clock,
   input logic         reset,
   rpn_req_if.sink     req,
   rpn_rsp_if.source   rsp
);
   rpn_cmd_type  cmd;
   rpn_stat_type stat;

   // sequencer
   rpn_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req.valid),
      .req_func        (req.func),
      .req_ready       (req.ready),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .stat            (stat),
      .cmd             (cmd),
      .shown_valid     (rsp.shown_valid),
      .unknown_command (rsp.unknown_command)
   );

   // stack and arithmetic
   rpn_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .func          (req.func),
      .operand_value (req.operand_value),
      .stat          (stat),
      .shown_value   (rsp.shown_value),
      .underflow     (rsp.underflow),
      .stack_full    (rsp.stack_full),
      .zero_divisor  (rsp.zero_divisor),
      .saturated     (rsp.saturated)
   );
endmodule

[bench/rpn_tb_if.sv]
// ---------------------------------------------------------------------------
// rpn_tb_if
// bench-side note: the channel interfaces come from the rtl; nothing here
// beyond a shared response record used by the checker
// ---------------------------------------------------------------------------
package rpn_tb_pkg;
   import rpn_pkg::*;

   typedef struct packed {
      value_type shown_value;
      logic      shown_valid;
      logic      underflow;
      logic      stack_full;
      logic      zero_divisor;
      logic      unknown_command;
      logic      saturated;
   } rpn_rsp_type;

endpackage

[bench/rpn_checker.sv]
// ---------------------------------------------------------------------------
// rpn_checker
// watches request and response channels, predicts responses, compares them
// ---------------------------------------------------------------------------
module rpn_checker import rpn_pkg::*; import rpn_tb_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   rpn_req_if     req,
   rpn_rsp_if     rsp,
   output int     fail_count,
   output int     pending_count,
   output int     shown_count,
   output int     flag_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
   localparam longint VMIN = -VMAX - 1;

   value_type   held_values[STACK_DEPTH];
   int          depth_now;
   rpn_rsp_type expected_rsps[$];
   logic        under_f, full_f, sat_f;

   function automatic value_type take_top();
      if (depth_now > 0) begin
         depth_now--;
         return held_values[depth_now];
      end
      under_f = 1'b1;
      return '0;
   endfunction

   function automatic void put_top(value_type v);
      if (depth_now < STACK_DEPTH) begin
         held_values[depth_now] = v;
         depth_now++;
      end else begin
         full_f = 1'b1;
      end
   endfunction

   function automatic value_type clamp_value(logic signed [127:0] v);
      if (v > VMAX) begin
         sat_f = 1'b1;
         return value_type'(VMAX);
      end
      if (v < VMIN) begin
         sat_f = 1'b1;
         return value_type'(VMIN);
      end
      return value_type'(v);
   endfunction

   function automatic rpn_rsp_type evaluate_token(logic [2:0] fn, value_type opnd);
      rpn_rsp_type r;
      logic signed [127:0] a, b, t;
      r = '0;
      under_f = 1'b0;
      full_f  = 1'b0;
      sat_f   = 1'b0;
      case (fn)
         FUNC_PUSH: put_top(opnd);
         FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
            b = take_top();
            a = take_top();
            if (fn == FUNC_ADD) t = a + b;
            else if (fn == FUNC_SUB) t = a - b;
            else t = (a * b) / (128'sd1 <<< FRACTION_BITS); // truncates toward zero
            put_top(clamp_value(t));
         end
         FUNC_DIV, FUNC_REM: begin
            b = take_top();
            if (b == 0) begin
               r.zero_divisor = 1'b1;
            end else begin
               a = take_top();
               if (fn == FUNC_DIV) t = (a * (128'sd1 <<< FRACTION_BITS)) / b;
               else t = a % b;
               put_top(clamp_value(t));
            end
         end
         FUNC_SHOW: begin
            r.shown_value = take_top();
            r.shown_valid = 1'b1;
         end
         default: r.unknown_command = 1'b1;
      endcase
      r.underflow  = under_f;
      r.stack_full = full_f;
      r.saturated  = sat_f;
      return r;
   endfunction

   always @(posedge clock) begin
      rpn_rsp_type got, want;
      if (reset) begin
         depth_now = 0;
         expected_rsps.delete();
         fail_count    <= 0;
         shown_count   <= 0;
         flag_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req.valid && req.ready)
            expected_rsps.push_back(evaluate_token(req.func, req.operand_value));
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.shown_value, rsp.shown_valid, rsp.underflow, rsp.stack_full,
                    rsp.zero_divisor, rsp.unknown_command, rsp.saturated};
            if (expected_rsps.size() == 0) begin
               $display("%t: unexpected response %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%t: mismatch expected %h actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
               if (want.shown_valid) shown_count <= shown_count + 1;
               if (want.underflow | want.stack_full | want.zero_divisor | want.saturated)
                  flag_count <= flag_count + 1;
            end
         end
         pending_count <= expected_rsps.size();
      end
   end

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the rpn stack evaluator
// ---------------------------------------------------------------------------
// Directed tokens cover every command, extremes, empty and full stack, zero
// divisors and saturation; random well-formed expressions follow, mixed
// with noise. The checker module does all prediction and comparison.
module tb_top import rpn_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   int   fail_count, pending_count, shown_count, flag_count;
   int   sent_count;
   bit   hold_long;

   rpn_req_if req ();
   rpn_rsp_if rsp ();

   rpn_stack_evaluator dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   rpn_checker checker_i (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_count(pending_count),
      .shown_count(shown_count), .flag_count(flag_count));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // drive one request at the falling edge, hold until accepted
   task automatic send_request(logic [2:0] fn, value_type v);
      int g;
      g = gap_length();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.func          <= fn;
      req.operand_value <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic value_type random_value();
      case ($urandom_range(0, 5))
         0: return value_type'($urandom);
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return value_type'($urandom_range(0, 3) << 16);
         4: return -value_type'($urandom_range(0, 32'h3ffff));
         default: return value_type'($urandom_range(0, 32'h3ffff));
      endcase
   endfunction

   function automatic logic [2:0] random_operator();
      case ($urandom_range(0, 4))
         0: return FUNC_ADD;
         1: return FUNC_SUB;
         2: return FUNC_MUL;
         3: return FUNC_DIV;
         default: return FUNC_REM;
      endcase
   endfunction

   // response side: random stalls plus one long hold-off
   initial begin
      int g;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_long = 1'b0;
         end
         g = gap_length();
         if (g > 0) begin
            rsp.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int n;
      req.valid         = 1'b0;
      req.func          = FUNC_PUSH;
      req.operand_value = '0;
      reset             = 1'b1;
      sent_count        = 0;
      hold_long         = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty stack underflow on show and on an operator
      send_request(FUNC_SHOW, '0);
      send_request(FUNC_ADD, '0);
      send_request(FUNC_SHOW, '0);
      send_request(FUNC_UNK, 32'sh7fffffff);
      // saturation on add, sub, mul
      send_request(FUNC_PUSH, 32'sh7fffffff);
      send_request(FUNC_PUSH, 32'sh7fffffff);
      send_request(FUNC_ADD, '0);
      send_request(FUNC_PUSH, 32'sh80000000);
      send_request(FUNC_SUB, '0);
      send_request(FUNC_PUSH, 32'sh80000000);
      send_request(FUNC_MUL, '0);
      send_request(FUNC_SHOW, '0);
      // zero divisor keeps the dividend, then divide and remainder with signs
      send_request(FUNC_PUSH, -32'sd458752);
      send_request(FUNC_PUSH, '0);
      send_request(FUNC_DIV, '0);
      send_request(FUNC_PUSH, 32'sd131072);
      send_request(FUNC_REM, '0);
      send_request(FUNC_PUSH, 32'sh80000000);
      send_request(FUNC_PUSH, 32'sd1);
      send_request(FUNC_DIV, '0);
      send_request(FUNC_SHOW, '0);
      send_request(FUNC_PUSH, '0);
      send_request(FUNC_REM, '0);
      send_request(FUNC_SHOW, '0);

      // fill the stack past full while the receiver holds off
      hold_long = 1'b1;
      for (int i = 0; i < STACK_DEPTH + 3; i++) send_request(FUNC_PUSH, random_value());
      for (int i = 0; i < STACK_DEPTH + 2; i++) send_request(FUNC_SHOW, '0);

      // random expressions: push a few values, fold them, show; some noise
      while (sent_count < 850) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(3'($urandom_range(0, 7)), value_type'($urandom));
         end else begin
            n = $urandom_range(2, 5);
            for (int i = 0; i < n; i++) send_request(FUNC_PUSH, random_value());
            for (int i = 1; i < n; i++) send_request(random_operator(), value_type'($urandom));
            send_request(FUNC_SHOW, '0);
         end
      end
      req.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("run covered %0d requests, %0d shown values, %0d flagged responses",
               sent_count, shown_count, flag_count);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rpn_pkg.sv
rtl/core/rpn_if.sv
rtl/core/rpn_ram.sv
rtl/core/rpn_datapath.sv
rtl/core/rpn_ctrl.sv
rtl/core/rpn_stack_evaluator.sv
bench/rpn_tb_if.sv
bench/rpn_checker.sv
bench/tb_top.sv
